>>> src/lpcsf_pkg.sv
// shared types, constants and defaults for the lpc synthesis filter
// no dependencies; used by lpcsf_history, lpcsf_mac and lpc_synthesis_filter
`default_nettype none

package lpcsf_pkg;

  localparam int unsigned MaxOrderDef         = 32;
  localparam int unsigned CoefFractionBitsDef = 14;
  localparam int unsigned RescalePositionDef  = 64;
  localparam int unsigned FrameMaxDef         = 1024;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned CoefIdxW  = 10;
  localparam int unsigned ScaleW    = 5;
  localparam int unsigned OrderRegW = 6;
  localparam int unsigned AccW      = 64;
  localparam int unsigned PaddrW    = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    REG_ORDER      = 2'd0,
    REG_PREV_SCALE = 2'd1,
    REG_CUR_SCALE  = 2'd2
  } cfg_reg_e;

  // control from the sequencer to the history file
  typedef struct packed {
    logic              clear;
    logic              push;
    logic              rescale;
    logic              scale_up;
    logic [ScaleW-1:0] scale_amt;
  } hist_ctrl_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> src/lpcsf_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lpcsf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 528,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/lpcsf_history.sv
// history of recent output samples: clear, shift-in and per-entry rescale
// depends on lpcsf_pkg
`default_nettype none

module lpcsf_history #(
  parameter int unsigned MAX_ORDER = lpcsf_pkg::MaxOrderDef,
  localparam int unsigned HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  localparam int unsigned OW = $clog2(MAX_ORDER + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lpcsf_pkg::hist_ctrl_t              ctrl_i,
  input  wire logic [HW-1:0]                      rd_idx_i,
  input  wire logic [OW-1:0]                      order_i,
  input  wire logic [lpcsf_pkg::SampleW-1:0]      push_data_i,
  output logic      [lpcsf_pkg::SampleW-1:0]      rd_data_o
);

  logic [lpcsf_pkg::SampleW-1:0] hist_q [MAX_ORDER];
  logic [lpcsf_pkg::SampleW-1:0] raw;
  logic [lpcsf_pkg::SampleW-1:0] scaled;

  assign raw = hist_q[rd_idx_i];

  // scale up wraps, scale down is arithmetic
  always_comb begin
    if (ctrl_i.scale_up) begin
      scaled = raw << ctrl_i.scale_amt;
    end else begin
      scaled = lpcsf_pkg::SampleW'($signed(raw) >>> ctrl_i.scale_amt);
    end
  end

  assign rd_data_o = ctrl_i.rescale ? scaled : raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        hist_q[k] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        hist_q[k] <= '0;
      end
    end else if (ctrl_i.push) begin
      hist_q[0] <= push_data_i;
      // only entries below the order move
      for (int k = 1; k < MAX_ORDER; k++) begin
        if (OW'(k) < order_i) begin
          hist_q[k] <= hist_q[k-1];
        end
      end
    end else if (ctrl_i.rescale) begin
      hist_q[rd_idx_i] <= scaled;
    end
  end

endmodule

`default_nettype wire

>>> src/lpcsf_mac.sv
// shared signed 32x32 multiply-accumulate with 64-bit sum and rounding shift
// depends on lpcsf_pkg
`default_nettype none

module lpcsf_mac #(
  parameter int unsigned COEF_FRACTION_BITS = lpcsf_pkg::CoefFractionBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpcsf_pkg::mac_ctrl_t          ctrl_i,
  input  wire logic [lpcsf_pkg::SampleW-1:0] hist_i,
  input  wire logic [lpcsf_pkg::SampleW-1:0] coef_i,
  output logic                               busy_o,
  output logic      [lpcsf_pkg::SampleW-1:0] pred_o
);

  localparam logic [lpcsf_pkg::AccW-1:0] RoundBias =
      lpcsf_pkg::AccW'(1) << (COEF_FRACTION_BITS - 1);

  logic                              v1_q, v2_q;
  logic [lpcsf_pkg::SampleW-1:0]     hist_q;
  logic signed [lpcsf_pkg::AccW-1:0] prod_full;
  logic [lpcsf_pkg::AccW-1:0]        prod_q;
  logic [lpcsf_pkg::AccW-1:0]        acc_q;
  logic [lpcsf_pkg::AccW-1:0]        rounded;
  logic [lpcsf_pkg::AccW-1:0]        shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  // full 64-bit product of two sign-extended 32-bit words
  assign prod_full = lpcsf_pkg::AccW'($signed(hist_q)) * lpcsf_pkg::AccW'($signed(coef_i));

  // history word is registered to line up with the ram read data
  always_ff @(posedge clk_i) begin
    hist_q <= hist_i;
    if (v1_q) begin
      prod_q <= prod_full;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign rounded = acc_q + RoundBias;
  assign shifted = lpcsf_pkg::AccW'($signed(rounded) >>> COEF_FRACTION_BITS);
  assign pred_o  = shifted[lpcsf_pkg::SampleW-1:0];
  assign busy_o  = v1_q | v2_q;

endmodule

`default_nettype wire

>>> src/lpc_synthesis_filter.sv
// lpc synthesis filter
// An item on the input channel either loads one coefficient word (func 0) or
// delivers one residual sample (func 1). A coefficient load gives no
// result. A residual sample gives one reconstructed sample on the
// output channel: the residual plus the rounded prediction from the taps of
// order min(sample index, predictor_order).
// A sample runs the taps one per cycle through a single shared multiplier;
// with eff taps (0 to 32), the taps are issued, the multiply pipeline
// drains, and the sample is finished into the output register before the
// block is idle again and takes the next item.
// The input is not ready while a sample is in the multiply-accumulate loop.
// The finished sample sits in an output register; if the receiver stalls,
// the next item is still taken, and a following sample waits only at its end
// for the register to drain.
// frame_start with a sample clears the history and sample index first.
// Reset clears the history, sample index and registers; the coefficient ram
// is not cleared and every word must be loaded before it is used.
// The user must write registers through the apb port only while the block is idle; the block does not enforce it.
// depends on lpcsf_pkg, lpcsf_ram, lpcsf_history, lpcsf_mac
`default_nettype none

module lpc_synthesis_filter #(
  parameter int unsigned MAX_ORDER          = lpcsf_pkg::MaxOrderDef,
  parameter int unsigned COEF_FRACTION_BITS = lpcsf_pkg::CoefFractionBitsDef,
  parameter int unsigned RESCALE_POSITION   = lpcsf_pkg::RescalePositionDef,
  parameter int unsigned FRAME_MAX          = lpcsf_pkg::FrameMaxDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  func_i,
  input  wire logic [lpcsf_pkg::CoefIdxW-1:0]        coef_index_i,
  input  wire logic signed [lpcsf_pkg::SampleW-1:0]  coef_value_i,
  input  wire logic signed [lpcsf_pkg::SampleW-1:0]  residual_sample_i,
  input  wire logic                                  frame_start_i,
  // output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [lpcsf_pkg::SampleW-1:0]       sample_out_o,
  // configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lpcsf_pkg::PaddrW-1:0]          paddr,
  input  wire logic [31:0]                           pwdata,
  output logic      [31:0]                           prdata,
  output logic                                       pready
);

  localparam int unsigned StoreSize = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int unsigned AW = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned OW = $clog2(MAX_ORDER + 1);
  localparam int unsigned IW = $clog2(FRAME_MAX + 1);
  localparam int unsigned CW = (IW > OW) ? IW : OW;
  localparam bit RescaleOn = RESCALE_POSITION < FRAME_MAX;
  localparam logic [IW-1:0] RescaleIdx = RescaleOn ? IW'(RESCALE_POSITION) : '0;

  // configuration registers
  logic [lpcsf_pkg::OrderRegW-1:0] order_q;
  logic [lpcsf_pkg::ScaleW-1:0]    prev_scale_q, cur_scale_q;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q      <= '0;
      prev_scale_q <= '0;
      cur_scale_q  <= '0;
    end else if (cfg_wr) begin
      unique case (lpcsf_pkg::cfg_reg_e'(paddr[3:2]))
        lpcsf_pkg::REG_ORDER:      order_q      <= pwdata[lpcsf_pkg::OrderRegW-1:0];
        lpcsf_pkg::REG_PREV_SCALE: prev_scale_q <= pwdata[lpcsf_pkg::ScaleW-1:0];
        lpcsf_pkg::REG_CUR_SCALE:  cur_scale_q  <= pwdata[lpcsf_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (lpcsf_pkg::cfg_reg_e'(paddr[3:2]))
      lpcsf_pkg::REG_ORDER:      prdata = 32'(order_q);
      lpcsf_pkg::REG_PREV_SCALE: prdata = 32'(prev_scale_q);
      lpcsf_pkg::REG_CUR_SCALE:  prdata = 32'(cur_scale_q);
      default:                   prdata = '0;
    endcase
  end

  // sequencer state
  lpcsf_pkg::state_e             state_q, state_d;
  logic [IW-1:0]                 idx_q;
  logic [OW-1:0]                 eff_q, j_q;
  logic [AW-1:0]                 offset_q;
  logic                          rescale_q;
  logic [lpcsf_pkg::SampleW-1:0] residual_q;
  logic                          out_valid_q;
  logic [lpcsf_pkg::SampleW-1:0] sample_out_q;

  logic                          in_xfer, coef_load, sample_start;
  logic                          issue, finish, mac_busy;
  logic [OW-1:0]                 ord_sat, eff_new;
  logic [IW-1:0]                 idx_new;
  logic [2*OW-1:0]               tri_prod;
  logic [AW-1:0]                 offset_new;
  logic                          rescale_new;
  logic [lpcsf_pkg::SampleW-1:0] hist_rd, coef_rd, pred, y;
  lpcsf_pkg::hist_ctrl_t         hist_ctrl;
  lpcsf_pkg::mac_ctrl_t          mac_ctrl;

  assign in_xfer      = in_valid_i & in_ready_o;
  assign coef_load    = in_xfer & ~func_i;
  assign sample_start = in_xfer & func_i;

  // per-sample setup: effective order and row offset of the triangular store
  assign ord_sat = (order_q > lpcsf_pkg::OrderRegW'(MAX_ORDER)) ? OW'(MAX_ORDER)
                                                                 : order_q[OW-1:0];
  assign idx_new = frame_start_i ? '0 : idx_q;
  assign eff_new = (CW'(idx_new) < CW'(ord_sat)) ? OW'(idx_new) : ord_sat;
  assign tri_prod = (2*OW)'(eff_new) * (2*OW)'(eff_new - OW'(1));
  assign offset_new = (eff_new == '0) ? '0 : AW'(tri_prod >> 1);
  assign rescale_new = RescaleOn && (idx_new == RescaleIdx) &&
                       (prev_scale_q != cur_scale_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpcsf_pkg::ST_IDLE: if (sample_start) state_d = lpcsf_pkg::ST_RUN;
      lpcsf_pkg::ST_RUN:  if (!issue && !mac_busy) state_d = lpcsf_pkg::ST_DONE;
      lpcsf_pkg::ST_DONE: if (finish) state_d = lpcsf_pkg::ST_IDLE;
      default:            state_d = lpcsf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      lpcsf_pkg::ST_IDLE: in_ready_o = 1'b1;
      lpcsf_pkg::ST_RUN:  issue      = j_q < eff_q;
      lpcsf_pkg::ST_DONE: finish     = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpcsf_pkg::ST_IDLE;
      idx_q       <= '0;
      eff_q       <= '0;
      j_q         <= '0;
      rescale_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sample_start) begin
        idx_q     <= idx_new;
        eff_q     <= eff_new;
        j_q       <= '0;
        rescale_q <= rescale_new;
      end else if (issue) begin
        j_q <= j_q + OW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (idx_q < IW'(FRAME_MAX)) begin
          idx_q <= idx_q + IW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_start) begin
      offset_q   <= offset_new;
      residual_q <= residual_sample_i;
    end
    if (finish) begin
      sample_out_q <= y;
    end
  end

  assign y = residual_q + pred;

  assign hist_ctrl.clear     = sample_start & frame_start_i;
  assign hist_ctrl.push      = finish;
  assign hist_ctrl.rescale   = rescale_q & issue;
  assign hist_ctrl.scale_up  = prev_scale_q > cur_scale_q;
  assign hist_ctrl.scale_amt = hist_ctrl.scale_up ? (prev_scale_q - cur_scale_q)
                                                  : (cur_scale_q - prev_scale_q);

  assign mac_ctrl.clear = sample_start;
  assign mac_ctrl.issue = issue;

  lpcsf_ram #(
    .WIDTH(lpcsf_pkg::SampleW),
    .DEPTH(StoreSize)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_load && (coef_index_i < lpcsf_pkg::CoefIdxW'(StoreSize))),
    .waddr_i(coef_index_i[AW-1:0]),
    .wdata_i(coef_value_i),
    .raddr_i(offset_q + AW'(j_q)),
    .rdata_o(coef_rd)
  );

  lpcsf_history #(
    .MAX_ORDER(MAX_ORDER)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hist_ctrl),
    .rd_idx_i   (j_q[HW-1:0]),
    .order_i    (ord_sat),
    .push_data_i(y),
    .rd_data_o  (hist_rd)
  );

  lpcsf_mac #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .hist_i(hist_rd),
    .coef_i(coef_rd),
    .busy_o(mac_busy),
    .pred_o(pred)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

`ifndef ASSERT_OFF
  // the multiply pipeline has drained before the sequencer is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpcsf_pkg::ST_IDLE |-> !mac_busy)
    else $error("mac busy while idle");

  // tap counter never runs past the effective order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpcsf_pkg::ST_RUN |-> j_q <= eff_q)
    else $error("tap counter overrun");

  // sample index saturates at the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(FRAME_MAX))
    else $error("sample index above frame limit");

  // every finished sample shows up on the output at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && sample_out_o == $past(y))
    else $error("finished sample not presented");
`endif

endmodule

`default_nettype wire
